// ===== design/nsc_pkg.sv =====
// Shared constants, codes and types of the NFA subset construction engine.
`default_nettype none
package nsc_pkg;

    localparam int NFA_Q_MAX   = 64;
    localparam int SYMBOLS     = 16;
    localparam int DFA_ID_MAX  = 4096;
    localparam int MAP_BUCKETS = 8192;

    localparam int QW   = $clog2(NFA_Q_MAX);       // NFA state index
    localparam int SW   = $clog2(SYMBOLS);         // symbol
    localparam int RAW  = QW + SW;                 // row store address
    localparam int IDW  = $clog2(DFA_ID_MAX);      // DFA id
    localparam int CNTW = IDW + 1;                 // DFA count, worklist top
    localparam int MAW  = $clog2(MAP_BUCKETS);     // map bucket index
    localparam int MDW  = IDW + 1;                 // map entry: id + 1, zero empty
    localparam int MASKW = 64;

    localparam logic [63:0] HASH_BASIS = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] HASH_PRIME = 64'h0000_0100_0000_01B3;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_EXPAND = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] STS_TRANS = 2'd0;
    localparam logic [1:0] STS_START = 2'd1;
    localparam logic [1:0] STS_EMPTY = 2'd2;
    localparam logic [1:0] STS_OVFL  = 2'd3;

    localparam logic [1:0] CFG_SYMBOLS = 2'd0;
    localparam logic [1:0] CFG_CAP     = 2'd1;
    localparam logic [1:0] CFG_START   = 2'd2;
    localparam logic [1:0] CFG_ACCEPT  = 2'd3;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_POP,
        ST_POP_WAIT,
        ST_SRC,
        ST_GATHER,
        ST_HASH,
        ST_PROBE,
        ST_PROBE_CHK,
        ST_CMP,
        ST_NEW,
        ST_FAIL,
        ST_RESULT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]     status;
        logic [IDW-1:0] source_state;
        logic [SW-1:0]  out_symbol;
        logic [IDW-1:0] next_state;
        logic           source_accepting;
        logic           last;
    } result_t;

endpackage
`default_nettype wire

// ===== design/nsc_ram.sv =====
// Generic single-port synchronous RAM with registered read.
`default_nettype none
module nsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

// ===== design/nsc_obuf.sv =====
// Output register stage: holds one result item for the master side.
`default_nettype none
module nsc_obuf (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire nsc_pkg::result_t in_res,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [31:0]           m_tdata,
    output logic [1:0]            m_tuser,
    output logic                  m_tlast
);

    logic             valid_reg;
    nsc_pkg::result_t res_reg;

    assign in_ready = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            res_reg <= in_res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.status;
    assign m_tlast  = res_reg.last;
    assign m_tdata  = {3'b000, res_reg.source_accepting, res_reg.next_state,
                       res_reg.out_symbol, res_reg.source_state};

endmodule
`default_nettype wire

// ===== design/nfa_subset_construction.sv =====
// Top level of the NFA-to-DFA subset construction engine.
`default_nettype none
// Builds a DFA from an epsilon-free NFA of up to 64 states and 16 symbols.
// Items on the slave side carry an opcode in s_tuser: load writes one NFA
// row (destination mask for a state and symbol) and gives no result; start
// clears the intern map, interns {start_state} as DFA state 0 and gives one
// result; expand pops one DFA state from the LIFO worklist and gives one
// transition per symbol in use or one empty result; an overflow result ends it.
// After reset the row store and intern map are swept clear before the
// first item is taken. A start clears the intern map again and then
// interns one subset. An expand pops an id from the worklist and fetches
// its subset, then per symbol walks the 64 NFA rows through the row
// store's single port, hashes the gathered subset, probes the map, and
// forms and hands over the result. The row store, intern map, subset
// pool and worklist sit in single-port RAMs with registered read; one
// item is worked on at a time, and a finished result sits in an output
// register so the engine goes on to the next result while the master
// side stalls.
module nfa_subset_construction (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_wdata,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // nfa_state[5:0], symbol[9:6], row_mask[73:10]
    input  wire logic [1:0]  s_tuser,   // opcode[1:0]
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // source_state[11:0], out_symbol[15:12],
                                        // next_state[27:16], source_accepting[28]
    output logic [1:0]       m_tuser,   // status[1:0]
    output logic             m_tlast
);

    localparam int QW   = nsc_pkg::QW;
    localparam int SW   = nsc_pkg::SW;
    localparam int IDW  = nsc_pkg::IDW;
    localparam int CNTW = nsc_pkg::CNTW;
    localparam int MAW  = nsc_pkg::MAW;
    localparam int MDW  = nsc_pkg::MDW;
    localparam int MW   = nsc_pkg::MASKW;

    // configuration registers
    logic [4:0]    symbol_count_reg;
    logic [12:0]   cap_reg;
    logic [5:0]    start_state_reg;
    logic [MW-1:0] accept_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_count_reg <= 5'd4;
            cap_reg          <= 13'd4096;
            start_state_reg  <= '0;
            accept_mask_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                nsc_pkg::CFG_SYMBOLS: symbol_count_reg <= cfg_wdata[4:0];
                nsc_pkg::CFG_CAP:     cap_reg          <= cfg_wdata[12:0];
                nsc_pkg::CFG_START:   start_state_reg  <= cfg_wdata[5:0];
                nsc_pkg::CFG_ACCEPT:  accept_mask_reg  <= cfg_wdata;
                default:              ;
            endcase
        end
    end

    // effective symbol count (2..16) and state cap (0..4096)
    logic [4:0]    eff_syms;
    logic [CNTW-1:0] eff_cap;
    always_comb
    begin
        if (symbol_count_reg < 5'd2)
            eff_syms = 5'd2;
        else if (symbol_count_reg > 5'(nsc_pkg::SYMBOLS))
            eff_syms = 5'(nsc_pkg::SYMBOLS);
        else
            eff_syms = symbol_count_reg;
        if (cap_reg > 13'(nsc_pkg::DFA_ID_MAX))
            eff_cap = CNTW'(nsc_pkg::DFA_ID_MAX);
        else
            eff_cap = CNTW'(cap_reg);
    end

    // input fields
    logic [1:0]    in_op;
    logic [QW-1:0] in_q;
    logic [SW-1:0] in_sym;
    logic [MW-1:0] in_row;
    assign in_op  = s_tuser;
    assign in_q   = s_tdata[5:0];
    assign in_sym = s_tdata[9:6];
    assign in_row = s_tdata[73:10];

    nsc_pkg::state_t state_reg, state_next;
    logic            accept;
    assign accept = s_tvalid && s_tready;

    // control and datapath registers
    logic            boot_reg;          // sweep also clears the row store
    logic [MAW-1:0]  clr_reg;
    logic            is_start_reg;      // intern called from a start item
    logic            cap_hit_reg;
    logic [CNTW-1:0] top_reg;
    logic [CNTW-1:0] count_reg;
    logic [IDW-1:0]  sid_reg;
    logic [MW-1:0]   src_reg;
    logic            acc_reg;
    logic [SW-1:0]   sym_reg;
    logic [QW:0]     q_reg;
    logic            take_reg;          // row read last cycle belongs to the subset
    logic [MW-1:0]   key_reg;
    logic [MAW-1:0]  bucket_reg;
    logic [MAW-1:0]  probes_reg;
    logic [IDW-1:0]  id_reg;
    nsc_pkg::result_t res_reg;

    // memories
    logic            row_we;
    logic [nsc_pkg::RAW-1:0] row_addr;
    logic [MW-1:0]   row_wdata, row_rdata;
    logic            map_we;
    logic [MAW-1:0]  map_addr;
    logic [MDW-1:0]  map_wdata, map_rdata;
    logic            pool_we;
    logic [IDW-1:0]  pool_addr;
    logic [MW-1:0]   pool_rdata;
    logic            wl_we;
    logic [IDW-1:0]  wl_addr;
    logic [IDW-1:0]  wl_rdata;

    nsc_ram #(.WIDTH(MW), .DEPTH(nsc_pkg::NFA_Q_MAX * nsc_pkg::SYMBOLS)) u_rows (
        .clk(clk), .we(row_we), .addr(row_addr), .wdata(row_wdata), .rdata(row_rdata));
    nsc_ram #(.WIDTH(MDW), .DEPTH(nsc_pkg::MAP_BUCKETS)) u_map (
        .clk(clk), .we(map_we), .addr(map_addr), .wdata(map_wdata), .rdata(map_rdata));
    nsc_ram #(.WIDTH(MW), .DEPTH(nsc_pkg::DFA_ID_MAX)) u_pool (
        .clk(clk), .we(pool_we), .addr(pool_addr), .wdata(key_reg), .rdata(pool_rdata));
    nsc_ram #(.WIDTH(IDW), .DEPTH(nsc_pkg::DFA_ID_MAX)) u_wl (
        .clk(clk), .we(wl_we), .addr(wl_addr), .wdata(count_reg[IDW-1:0]),
        .rdata(wl_rdata));

    // output stage
    logic ob_valid, ob_ready;
    nsc_obuf u_obuf (
        .clk(clk), .rst_n(rst_n), .in_valid(ob_valid), .in_ready(ob_ready),
        .in_res(res_reg), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast));

    // map entry that the current probe found, minus one
    logic [IDW-1:0] cand_id;
    assign cand_id = IDW'(map_rdata - MDW'(1));

    // FNV-1a bucket: only the low bits of the product reach the index
    logic [2*MAW-1:0] hash_prod;
    assign hash_prod = (key_reg[MAW-1:0] ^ nsc_pkg::HASH_BASIS[MAW-1:0])
                     * nsc_pkg::HASH_PRIME[MAW-1:0];

    logic last_sym;
    assign last_sym = ({1'b0, sym_reg} == eff_syms - 5'd1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nsc_pkg::ST_CLR:
                if (clr_reg == MAW'(nsc_pkg::MAP_BUCKETS - 1))
                    state_next = boot_reg ? nsc_pkg::ST_IDLE : nsc_pkg::ST_HASH;
            nsc_pkg::ST_IDLE:
                if (accept)
                begin
                    if (in_op == nsc_pkg::OP_START)
                        state_next = nsc_pkg::ST_CLR;
                    else if (in_op == nsc_pkg::OP_EXPAND)
                        state_next = (cap_hit_reg || top_reg == '0)
                                   ? nsc_pkg::ST_EMIT : nsc_pkg::ST_POP;
                end
            nsc_pkg::ST_POP:       state_next = nsc_pkg::ST_POP_WAIT;
            nsc_pkg::ST_POP_WAIT:  state_next = nsc_pkg::ST_SRC;
            nsc_pkg::ST_SRC:       state_next = nsc_pkg::ST_GATHER;
            nsc_pkg::ST_GATHER:
                if (q_reg == (QW+1)'(nsc_pkg::NFA_Q_MAX))
                    state_next = nsc_pkg::ST_HASH;
            nsc_pkg::ST_HASH:      state_next = nsc_pkg::ST_PROBE;
            nsc_pkg::ST_PROBE:     state_next = nsc_pkg::ST_PROBE_CHK;
            nsc_pkg::ST_PROBE_CHK:
                if (map_rdata == '0)
                    state_next = (count_reg >= eff_cap) ? nsc_pkg::ST_FAIL : nsc_pkg::ST_NEW;
                else
                    state_next = nsc_pkg::ST_CMP;
            nsc_pkg::ST_CMP:
                if (pool_rdata == key_reg)
                    state_next = nsc_pkg::ST_RESULT;
                else if (probes_reg == MAW'(nsc_pkg::MAP_BUCKETS - 1))
                    state_next = nsc_pkg::ST_FAIL;
                else
                    state_next = nsc_pkg::ST_PROBE;
            nsc_pkg::ST_NEW:       state_next = nsc_pkg::ST_RESULT;
            nsc_pkg::ST_FAIL:      state_next = nsc_pkg::ST_EMIT;
            nsc_pkg::ST_RESULT:    state_next = nsc_pkg::ST_EMIT;
            nsc_pkg::ST_EMIT:
                if (ob_ready)
                    state_next = res_reg.last ? nsc_pkg::ST_IDLE : nsc_pkg::ST_GATHER;
            default:      state_next = nsc_pkg::ST_IDLE;
        endcase
    end

    // memory controls and handshake outputs
    always_comb
    begin
        s_tready  = (state_reg == nsc_pkg::ST_IDLE);
        ob_valid  = (state_reg == nsc_pkg::ST_EMIT);
        row_we    = 1'b0;
        row_addr  = {in_q, in_sym};
        row_wdata = in_row;
        map_we    = 1'b0;
        map_addr  = bucket_reg;
        map_wdata = MDW'(count_reg) + MDW'(1);
        pool_we   = 1'b0;
        pool_addr = cand_id;
        wl_we     = 1'b0;
        wl_addr   = top_reg[IDW-1:0];
        case (state_reg)
            nsc_pkg::ST_CLR:
            begin
                map_we    = 1'b1;
                map_addr  = clr_reg;
                map_wdata = '0;
                row_we    = boot_reg
                          && (clr_reg < MAW'(nsc_pkg::NFA_Q_MAX * nsc_pkg::SYMBOLS));
                row_addr  = clr_reg[nsc_pkg::RAW-1:0];
                row_wdata = '0;
            end
            nsc_pkg::ST_IDLE:
                row_we = accept && (in_op == nsc_pkg::OP_LOAD);
            nsc_pkg::ST_POP_WAIT:
                pool_addr = wl_rdata;
            nsc_pkg::ST_GATHER:
                row_addr = {q_reg[QW-1:0], sym_reg};
            nsc_pkg::ST_NEW:
            begin
                map_we    = 1'b1;
                pool_we   = 1'b1;
                pool_addr = count_reg[IDW-1:0];
                wl_we     = !top_reg[IDW];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= nsc_pkg::ST_CLR;
            boot_reg    <= 1'b1;
            clr_reg     <= '0;
            is_start_reg <= 1'b0;
            cap_hit_reg <= 1'b0;
            top_reg     <= '0;
            count_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                nsc_pkg::ST_CLR:
                begin
                    clr_reg <= clr_reg + MAW'(1);
                    if (clr_reg == MAW'(nsc_pkg::MAP_BUCKETS - 1))
                        boot_reg <= 1'b0;
                end
                nsc_pkg::ST_IDLE:
                    if (accept && in_op == nsc_pkg::OP_START)
                    begin
                        is_start_reg <= 1'b1;
                        cap_hit_reg  <= 1'b0;
                        top_reg      <= '0;
                        count_reg    <= '0;
                    end
                    else if (accept && in_op == nsc_pkg::OP_EXPAND)
                    begin
                        is_start_reg <= 1'b0;
                        if (!cap_hit_reg && top_reg != '0)
                            top_reg <= top_reg - CNTW'(1);
                    end
                nsc_pkg::ST_NEW:
                begin
                    count_reg <= count_reg + CNTW'(1);
                    if (!top_reg[IDW])
                        top_reg <= top_reg + CNTW'(1);
                end
                nsc_pkg::ST_FAIL:
                    cap_hit_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            nsc_pkg::ST_IDLE:
                if (accept)
                begin
                    key_reg <= MW'(1) << start_state_reg;
                    // single empty / overflow result: status, zero fields, last set
                    res_reg <= {(cap_hit_reg ? nsc_pkg::STS_OVFL : nsc_pkg::STS_EMPTY),
                                29'd0, 1'b1};
                end
            nsc_pkg::ST_POP_WAIT:
                sid_reg <= wl_rdata;
            nsc_pkg::ST_SRC:
            begin
                src_reg  <= pool_rdata;
                acc_reg  <= (pool_rdata & accept_mask_reg) != '0;
                sym_reg  <= '0;
                q_reg    <= '0;
                take_reg <= 1'b0;
                key_reg  <= '0;
            end
            nsc_pkg::ST_GATHER:
            begin
                if (take_reg)
                    key_reg <= key_reg | row_rdata;
                take_reg <= (q_reg < (QW+1)'(nsc_pkg::NFA_Q_MAX)) && src_reg[q_reg[QW-1:0]];
                q_reg    <= q_reg + (QW+1)'(1);
            end
            nsc_pkg::ST_HASH:
            begin
                bucket_reg <= hash_prod[MAW-1:0];
                probes_reg <= '0;
            end
            nsc_pkg::ST_CMP:
            begin
                id_reg     <= cand_id;
                bucket_reg <= bucket_reg + MAW'(1);
                probes_reg <= probes_reg + MAW'(1);
            end
            nsc_pkg::ST_NEW:
                id_reg <= count_reg[IDW-1:0];
            nsc_pkg::ST_FAIL:
            begin
                res_reg.status     <= nsc_pkg::STS_OVFL;
                res_reg.next_state <= '0;
                res_reg.last       <= 1'b1;
                if (is_start_reg)
                begin
                    res_reg.source_state     <= '0;
                    res_reg.out_symbol       <= '0;
                    res_reg.source_accepting <= 1'b0;
                end
                else
                begin
                    res_reg.source_state     <= sid_reg;
                    res_reg.out_symbol       <= sym_reg;
                    res_reg.source_accepting <= acc_reg;
                end
            end
            nsc_pkg::ST_RESULT:
                if (is_start_reg)
                begin
                    res_reg.status           <= nsc_pkg::STS_START;
                    res_reg.source_state     <= '0;
                    res_reg.out_symbol       <= '0;
                    res_reg.next_state       <= '0;
                    res_reg.source_accepting <= (key_reg & accept_mask_reg) != '0;
                    res_reg.last             <= 1'b1;
                end
                else
                begin
                    res_reg.status           <= nsc_pkg::STS_TRANS;
                    res_reg.source_state     <= sid_reg;
                    res_reg.out_symbol       <= sym_reg;
                    res_reg.next_state       <= id_reg;
                    res_reg.source_accepting <= acc_reg;
                    res_reg.last             <= last_sym;
                end
            nsc_pkg::ST_EMIT:
                if (ob_ready && !res_reg.last)
                begin
                    sym_reg  <= sym_reg + SW'(1);
                    q_reg    <= '0;
                    take_reg <= 1'b0;
                    key_reg  <= '0;
                end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ===== design/nsc_checker.sv =====
// Port-level checks of the subset construction engine, bound to the top level.
`default_nettype none
module nsc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    a_start_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == nsc_pkg::STS_START |-> m_tlast && m_tdata[27:0] == 28'd0)
        else $error("start result malformed");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == nsc_pkg::STS_EMPTY |-> m_tlast && m_tdata == 32'd0)
        else $error("empty result malformed");

    a_ovfl_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == nsc_pkg::STS_OVFL |-> m_tlast && m_tdata[27:16] == 12'd0)
        else $error("overflow result malformed");

endmodule

bind nfa_subset_construction nsc_checker u_nsc_checker (
    .clk(clk), .rst_n(rst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast));
`default_nettype wire
